// ----- hdl/gprd_pkg.sv -----
`timescale 1ns / 1ps
// gprd_pkg: types and constants for the gamepad report decoder
// no dependencies; used by gamepad_report_decoder_core

package gprd_pkg;

   // only the leading report bytes take part in decode
   localparam int DEC_BYTES = 18;
   localparam int DEC_IDX_W = $clog2(DEC_BYTES);

   localparam logic [7:0] HDR_NULL   = 8'h00;
   localparam logic [7:0] HDR_LED    = 8'h01;
   localparam logic [7:0] HDR_AUTH   = 8'h02;
   localparam logic [7:0] HDR_LEDSUB = 8'h03;
   localparam logic [7:0] HDR_GUIDE  = 8'h07;
   localparam logic [7:0] HDR_WIRED  = 8'h14;
   localparam logic [7:0] HDR_INPUT  = 8'h20;
   localparam logic [7:0] LED_CODE   = 8'h06;

   typedef enum logic [1:0] {
      KIND_STATE = 2'd0,
      KIND_LED   = 2'd1,
      KIND_AUTH  = 2'd2
   } kind_type;

   typedef enum logic {
      CTYPE_WIRED = 1'b0,
      CTYPE_ONE   = 1'b1
   } ctype_type;

   typedef struct packed {
      logic        [14:0] buttons;
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic        [15:0] left_trigger;
      logic        [15:0] right_trigger;
   } pad_state_type;

   typedef struct packed {
      kind_type      kind;
      pad_state_type pad;
      logic [7:0]    code;
      logic          last;
   } result_type;

endpackage

// ----- hdl/gamepad_report_decoder_core.sv -----
`timescale 1ns / 1ps
// results: the last byte sets the pending flag; the decode then commits into the result queue, whose head is offered
// throughput: one report byte per cycle; the decode stage and a two-entry result queue
// hold input back only while the queue has no room for what a report produces
// reset: synchronous, active high; clears report buffer, byte position, previous state,
// sequence number, controller type and the result queue
// depends on gprd_pkg

module gamepad_report_decoder_core #(
   parameter int BUFFER_BYTES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_report_byte,
   input  logic                req_report_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_result_kind,
   output logic [14:0]         rsp_buttons,
   output logic signed [15:0]  rsp_left_x,
   output logic signed [15:0]  rsp_left_y,
   output logic signed [15:0]  rsp_right_x,
   output logic signed [15:0]  rsp_right_y,
   output logic [15:0]         rsp_left_trigger,
   output logic [15:0]         rsp_right_trigger,
   output logic [7:0]          rsp_command_code,
   output logic                rsp_result_last
);

   localparam int POS_W = $clog2(BUFFER_BYTES + 1);

   logic [7:0]                   buf_ff [gprd_pkg::DEC_BYTES];
   logic [POS_W-1:0]             pos_ff;
   logic [POS_W-1:0]             pos_in;
   gprd_pkg::ctype_type          ctype_ff;
   logic                         pend_ff;
   logic                         pend_in;
   gprd_pkg::pad_state_type      prev_ff;
   gprd_pkg::pad_state_type      prev_in;
   logic [7:0]                   seq_ff;
   logic [7:0]                   seq_in;
   gprd_pkg::result_type         q_ff [2];
   gprd_pkg::result_type         q_in [2];
   logic [1:0]                   cnt_ff;
   logic [1:0]                   cnt_in;

   logic                         req_accept;
   logic                         pop;
   logic                         commit;
   logic [1:0]                   cnt_pop;
   logic [1:0]                   num_res;
   gprd_pkg::result_type         res0;
   gprd_pkg::result_type         res1;
   gprd_pkg::result_type         shf [2];
   gprd_pkg::pad_state_type      dec_state;
   gprd_pkg::pad_state_type      zero_state;
   logic                         upd_prev;
   logic                         upd_seq;
   logic [7:0]                   b0;
   logic [7:0]                   b1;
   logic [7:0]                   xb;
   logic                         differ;

   assign zero_state = '0;
   assign b0 = buf_ff[0];
   assign b1 = buf_ff[1];

   // decode of the stored report
   always_comb begin
      dec_state = zero_state;
      res0      = '0;
      res1      = '0;
      num_res   = 2'd0;
      upd_prev  = 1'b0;
      upd_seq   = 1'b0;
      differ    = 1'b0;
      xb        = 8'h00;
      if (ctype_ff == gprd_pkg::CTYPE_WIRED) begin
         if (b0 == gprd_pkg::HDR_NULL && b1 == gprd_pkg::HDR_WIRED) begin
            xb = buf_ff[3];
            dec_state.buttons       = {xb[7:4], xb[2:0], buf_ff[2]};
            dec_state.left_x        = {buf_ff[7], buf_ff[6]};
            dec_state.left_y        = {buf_ff[9], buf_ff[8]};
            dec_state.right_x       = {buf_ff[11], buf_ff[10]};
            dec_state.right_y       = {buf_ff[13], buf_ff[12]};
            dec_state.left_trigger  = {6'b0, buf_ff[4], 2'b00};
            dec_state.right_trigger = {6'b0, buf_ff[5], 2'b00};
         end
         differ   = (dec_state != prev_ff);
         upd_prev = differ;
         if (b0 == gprd_pkg::HDR_LED && b1 == gprd_pkg::HDR_LEDSUB) begin
            res0.kind = gprd_pkg::KIND_LED;
            res0.code = gprd_pkg::LED_CODE;
            res0.last = !differ;
            res1.kind = gprd_pkg::KIND_STATE;
            res1.pad  = dec_state;
            res1.last = 1'b1;
            num_res   = differ ? 2'd2 : 2'd1;
         end else begin
            res0.kind = gprd_pkg::KIND_STATE;
            res0.pad  = dec_state;
            res0.last = 1'b1;
            num_res   = differ ? 2'd1 : 2'd0;
         end
      end else begin
         num_res   = 2'd1;
         res0.last = 1'b1;
         if (b0 == gprd_pkg::HDR_AUTH && b1 == gprd_pkg::HDR_INPUT) begin
            res0.kind = gprd_pkg::KIND_AUTH;
            res0.code = seq_ff;
            upd_seq   = 1'b1;
         end else begin
            if (b0 == gprd_pkg::HDR_INPUT) begin
               xb = buf_ff[4];
               dec_state.buttons = {xb[7:4], 1'b0, buf_ff[5][5:4], buf_ff[5][7:6],
                                    xb[3:2], buf_ff[5][3:0]};
               dec_state.left_x        = {buf_ff[11], buf_ff[10]};
               dec_state.left_y        = {buf_ff[13], buf_ff[12]};
               dec_state.right_x       = {buf_ff[15], buf_ff[14]};
               dec_state.right_y       = {buf_ff[17], buf_ff[16]};
               dec_state.left_trigger  = {buf_ff[7], buf_ff[6]};
               dec_state.right_trigger = {buf_ff[9], buf_ff[8]};
            end else if (b0 == gprd_pkg::HDR_GUIDE && b1 == gprd_pkg::HDR_INPUT) begin
               dec_state = prev_ff;
               dec_state.buttons[10] = buf_ff[4][0];
            end
            res0.kind = gprd_pkg::KIND_STATE;
            res0.pad  = dec_state;
            upd_prev  = 1'b1;
         end
      end
   end

   // result queue and handshakes
   always_comb begin
      pop        = rsp_valid && !rsp_stall;
      cnt_pop    = cnt_ff - {1'b0, pop};
      commit     = pend_ff && (num_res <= (2'd2 - cnt_pop));
      req_stall  = pend_ff && !commit;
      req_accept = req_valid && !req_stall;
      shf[0]     = pop ? q_ff[1] : q_ff[0];
      shf[1]     = q_ff[1];
      for (int i = 0; i < 2; i++) begin
         q_in[i] = shf[i];
         if (commit) begin
            if (num_res != 2'd0 && cnt_pop == 2'(i)) begin
               q_in[i] = res0;
            end
            if (num_res == 2'd2 && cnt_pop + 2'd1 == 2'(i)) begin
               q_in[i] = res1;
            end
         end
      end
      cnt_in  = cnt_pop + (commit ? num_res : 2'd0);
      pend_in = req_accept ? req_report_last : (pend_ff && !commit);
      prev_in = (commit && upd_prev) ? dec_state : prev_ff;
      seq_in  = (commit && upd_seq) ? seq_ff + 8'd1 : seq_ff;
      pos_in  = pos_ff;
      if (req_accept) begin
         if (req_report_last) begin
            pos_in = '0;
         end else if (pos_ff != POS_W'(BUFFER_BYTES)) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gprd_pkg::DEC_BYTES; i++) begin
            buf_ff[i] <= 8'h00;
         end
         pos_ff   <= '0;
         ctype_ff <= gprd_pkg::CTYPE_WIRED;
         pend_ff  <= 1'b0;
         prev_ff  <= '0;
         seq_ff   <= 8'h00;
         cnt_ff   <= 2'd0;
      end else begin
         if (req_accept && pos_ff < POS_W'(gprd_pkg::DEC_BYTES)) begin
            buf_ff[pos_ff[gprd_pkg::DEC_IDX_W-1:0]] <= req_report_byte;
         end
         if (csr_wr_en) begin
            ctype_ff <= gprd_pkg::ctype_type'(csr_wr_data);
         end
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
         prev_ff <= prev_in;
         seq_ff  <= seq_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_valid         = (cnt_ff != 2'd0);
   assign rsp_result_kind   = q_ff[0].kind;
   assign rsp_buttons       = q_ff[0].pad.buttons;
   assign rsp_left_x        = q_ff[0].pad.left_x;
   assign rsp_left_y        = q_ff[0].pad.left_y;
   assign rsp_right_x       = q_ff[0].pad.right_x;
   assign rsp_right_y       = q_ff[0].pad.right_y;
   assign rsp_left_trigger  = q_ff[0].pad.left_trigger;
   assign rsp_right_trigger = q_ff[0].pad.right_trigger;
   assign rsp_command_code  = q_ff[0].code;
   assign rsp_result_last   = q_ff[0].last;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_stall_pend: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (pend_ff && cnt_ff != 2'd0))
      else $error("request stalled without a blocked decode");

   a_commit_clear: assert property (@(posedge clock) disable iff (reset)
      (commit && !(req_accept && req_report_last)) |=> !pend_ff)
      else $error("decode still pending after commit");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(BUFFER_BYTES))
      else $error("byte position past buffer end");

endmodule
